>>> src/rcpwc_pkg.sv
// ----------------------------------------------------------------------------
// rcpwc_pkg
// shared types, constants and codes of the rc pulse width capture core
// ----------------------------------------------------------------------------
package rcpwc_pkg;

    localparam int CHANNELS   = 4;
    localparam int TICK_BITS  = 32;
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CFG_IDX_W  = $clog2(CHANNELS + 2);
    localparam int PIN_W      = 5;
    localparam int WIDTH_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int DIV_STEPS  = FRAC_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // register indexes
    localparam int REG_MIN_WIDTH = CHANNELS;
    localparam int REG_MAX_WIDTH = CHANNELS + 1;

    localparam logic [WIDTH_W-1:0] MIN_WIDTH_RESET = 32'd1000;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH_RESET = 32'd2000;

    // edge levels
    localparam logic [1:0] LEVEL_FALL = 2'd0;
    localparam logic [1:0] LEVEL_RISE = 2'd1;

    typedef struct packed {
        logic [PIN_W-1:0] pin;
        logic [1:0]       level;
        logic [31:0]      tick;
    } rcpwc_in_t;

    typedef struct packed {
        logic [1:0]         channel;
        logic [WIDTH_W-1:0] width;
        logic [FRAC_W-1:0]  fraction;
    } rcpwc_out_t;

    typedef struct packed {
        logic load_item;
        logic write_rise;
        logic capture;
        logic div_start;
        logic load_out;
    } rcpwc_cmd_t;

    typedef struct packed {
        logic hit;
        logic level_rise;
        logic level_fall;
        logic rise_nonzero;
        logic div_done;
        logic out_free;
    } rcpwc_status_t;

endpackage

>>> src/rc_pulse_width_capture_core.sv
// ----------------------------------------------------------------------------
// rc_pulse_width_capture_core
// pulse width capture for radio-control receiver channels
// ----------------------------------------------------------------------------
// Each input item is one pin edge with its timestamp. The pin is matched
// against the per-channel pin registers (lowest channel wins, unmapped pins
// and levels other than rising or falling are dropped). A rising edge stores
// the timestamp; a falling edge with a nonzero stored rise produces one
// output item with the channel, the modular width and a 16-bit fraction of
// the width clamped to min..max. An edge that yields no output returns to
// idle after evaluation; a measured pulse also passes through the bit-serial
// divider that produces one fraction bit per cycle. The finished item sits
// in an output register, so the next edge is accepted while it waits.
// Configuration writes are always accepted and must be issued while idle.
module rc_pulse_width_capture_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  rcpwc_pkg::rcpwc_in_t                in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output rcpwc_pkg::rcpwc_out_t               out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rcpwc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                         cfg_data
);

    rcpwc_pkg::rcpwc_cmd_t    cmd;
    rcpwc_pkg::rcpwc_status_t status;

    assign cfg_ready = 1'b1;

    rcpwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rcpwc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> src/rcpwc_divider.sv
// ----------------------------------------------------------------------------
// rcpwc_divider
// restoring divider for floor(num * 65535 / den), one quotient bit per cycle
// ----------------------------------------------------------------------------
module rcpwc_divider (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [rcpwc_pkg::WIDTH_W-1:0]        num,
    input  logic [rcpwc_pkg::WIDTH_W-1:0]        den,
    output logic [rcpwc_pkg::FRAC_W-1:0]         quotient,
    output logic                                 done
);

    localparam int W = rcpwc_pkg::WIDTH_W;
    localparam int F = rcpwc_pkg::FRAC_W;

    logic                             busy_reg;
    logic                             busy_next;
    logic                             done_reg;
    logic                             done_next;
    logic [rcpwc_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [rcpwc_pkg::DIV_CNT_W-1:0]  cnt_next;
    logic [W-1:0]                     rem_reg;
    logic [W-1:0]                     rem_next;
    logic [F-1:0]                     lq_reg;
    logic [F-1:0]                     lq_next;

    logic [W+F-1:0] prod;
    logic [W:0]     trial;
    logic [W:0]     diff;
    logic           qbit;

    // num * 65535 as a shift and subtract
    assign prod  = {num, {F{1'b0}}} - {{F{1'b0}}, num};
    assign trial = {rem_reg, lq_reg[F-1]};
    assign diff  = trial - {1'b0, den};
    assign qbit  = ~diff[W];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        lq_next   = lq_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = rcpwc_pkg::DIV_CNT_W'(rcpwc_pkg::DIV_STEPS - 1);
            rem_next  = prod[W+F-1:F];
            lq_next   = prod[F-1:0];
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? diff[W-1:0] : trial[W-1:0];
            lq_next  = {lq_reg[F-2:0], qbit};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lq_reg  <= lq_next;
    end

    assign quotient = lq_reg;
    assign done     = done_reg;

    a_start_clears_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && !done_reg)
        else $error("divider start did not restart the division");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !start |=> done_reg && $stable(lq_reg))
        else $error("divider result changed while done");

endmodule

>>> src/rcpwc_datapath.sv
// ----------------------------------------------------------------------------
// rcpwc_datapath
// config registers, rise times, channel lookup, width and clamp, output slot
// ----------------------------------------------------------------------------
module rcpwc_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [rcpwc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                          cfg_data,
    input  rcpwc_pkg::rcpwc_in_t                 in_data,
    input  rcpwc_pkg::rcpwc_cmd_t                cmd,
    output rcpwc_pkg::rcpwc_status_t             status,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output rcpwc_pkg::rcpwc_out_t                out_data
);

    localparam int NCH = rcpwc_pkg::CHANNELS;
    localparam int TB  = rcpwc_pkg::TICK_BITS;
    localparam int W   = rcpwc_pkg::WIDTH_W;
    localparam int CW  = rcpwc_pkg::CH_IDX_W;

    logic [rcpwc_pkg::PIN_W-1:0] pin_reg [NCH];
    logic [W-1:0]                min_reg;
    logic [W-1:0]                max_reg;
    logic [TB-1:0]               rise_reg [NCH];

    rcpwc_pkg::rcpwc_in_t        item_reg;
    logic [CW-1:0]               ch_reg;
    logic [W-1:0]                width_reg;
    logic [W-1:0]                num_reg;
    logic [W-1:0]                den_reg;
    logic                        empty_reg;

    rcpwc_pkg::rcpwc_out_t       out_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;

    logic                        hit;
    logic [CW-1:0]               ch;
    logic [TB-1:0]               tick_cut;
    logic [TB-1:0]               rise_sel;
    logic [W-1:0]                width_cur;
    logic [W-1:0]                clamped;
    logic [rcpwc_pkg::FRAC_W-1:0] quotient;
    logic                        div_done;

    // lowest matching channel wins
    always_comb
    begin
        hit = 1'b0;
        ch  = '0;
        for (int k = NCH - 1; k >= 0; k--)
        begin
            if (pin_reg[k] == item_reg.pin)
            begin
                hit = 1'b1;
                ch  = CW'(k);
            end
        end
    end

    assign tick_cut  = item_reg.tick[TB-1:0];
    assign rise_sel  = rise_reg[ch];
    assign width_cur = W'(tick_cut - rise_sel);

    always_comb
    begin
        priority if (width_cur < min_reg)
            clamped = min_reg;
        else if (width_cur > max_reg)
            clamped = max_reg;
        else
            clamped = width_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NCH; k++)
            begin
                pin_reg[k]  <= rcpwc_pkg::PIN_W'(k);
                rise_reg[k] <= '0;
            end
            min_reg <= rcpwc_pkg::MIN_WIDTH_RESET;
            max_reg <= rcpwc_pkg::MAX_WIDTH_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                for (int k = 0; k < NCH; k++)
                begin
                    if (cfg_index == rcpwc_pkg::CFG_IDX_W'(k))
                        pin_reg[k] <= cfg_data[rcpwc_pkg::PIN_W-1:0];
                end
                if (cfg_index == rcpwc_pkg::CFG_IDX_W'(rcpwc_pkg::REG_MIN_WIDTH))
                    min_reg <= cfg_data;
                if (cfg_index == rcpwc_pkg::CFG_IDX_W'(rcpwc_pkg::REG_MAX_WIDTH))
                    max_reg <= cfg_data;
            end
            if (cmd.write_rise)
                rise_reg[ch] <= tick_cut;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= in_data;
        if (cmd.capture)
        begin
            ch_reg    <= ch;
            width_reg <= width_cur;
            num_reg   <= clamped - min_reg;
            den_reg   <= max_reg - min_reg;
            empty_reg <= (max_reg <= min_reg);
        end
        if (cmd.load_out)
        begin
            out_reg.channel  <= 2'(ch_reg);
            out_reg.width    <= width_reg;
            out_reg.fraction <= empty_reg ? '0 : quotient;
        end
    end

    rcpwc_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .num      (num_reg),
        .den      (den_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign status.hit          = hit;
    assign status.level_rise   = (item_reg.level == rcpwc_pkg::LEVEL_RISE);
    assign status.level_fall   = (item_reg.level == rcpwc_pkg::LEVEL_FALL);
    assign status.rise_nonzero = (rise_sel != '0);
    assign status.div_done     = div_done;
    assign status.out_free     = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.load_out))
        else $error("output item appeared without a load");

endmodule

>>> src/rcpwc_ctrl.sv
// ----------------------------------------------------------------------------
// rcpwc_ctrl
// sequencer: accept, evaluate, divide, hand result to the output slot
// ----------------------------------------------------------------------------
module rcpwc_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  rcpwc_pkg::rcpwc_status_t status,
    output rcpwc_pkg::rcpwc_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EVAL  = 5'b00010,
        S_START = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_IDLE;
                if (status.hit && status.level_rise)
                    cmd.write_rise = 1'b1;
                else if (status.hit && status.level_fall && status.rise_nonzero)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_load_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.div_done)
        else $error("result loaded before the division finished");

    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_item |=> state_reg == S_EVAL)
        else $error("accepted item not evaluated next");

endmodule

>>> verif/rc_pulse_width_capture_core_checker.sv
// ----------------------------------------------------------------------------
// rc_pulse_width_capture_core_checker
// predicts pulse measurements from accepted edges and checks every output item
// ----------------------------------------------------------------------------
// Follows the pin map and the min/max range through the register port. Keeps
// its own rise timestamp per channel. Expects one item for each falling edge
// that has a nonzero rise time. Output items are compared in order against
// the oldest expected measurement. The failure count and the number of items
// still due are passed up to the testbench top.
module rc_pulse_width_capture_core_checker
    import rcpwc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  rcpwc_in_t             in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  rcpwc_out_t            out_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]           cfg_data,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [PIN_W-1:0]     pin_map [CHANNELS];
    logic [WIDTH_W-1:0]   min_w;
    logic [WIDTH_W-1:0]   max_w;
    logic [TICK_BITS-1:0] rise_at [CHANNELS];
    rcpwc_out_t           pulses_due [$];

    function automatic logic [FRAC_W-1:0] pulse_fraction(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W-1:0] c;
        logic [63:0]        prod;
        if (max_w <= min_w)
        begin
            return '0;
        end
        c = (w < min_w) ? min_w : ((w > max_w) ? max_w : w);
        prod = 64'(c - min_w) * 64'd65535;
        return FRAC_W'(prod / 64'(max_w - min_w));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        rcpwc_out_t due;
        int         ch;
        if (!rst_n)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                pin_map[k] = PIN_W'(k);
                rise_at[k] = '0;
            end
            min_w = MIN_WIDTH_RESET;
            max_w = MAX_WIDTH_RESET;
            pulses_due.delete();
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index < CHANNELS)
                    pin_map[cfg_index] = cfg_data[PIN_W-1:0];
                else if (cfg_index == REG_MIN_WIDTH)
                    min_w = cfg_data;
                else if (cfg_index == REG_MAX_WIDTH)
                    max_w = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                if (pulses_due.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    $display("%0t: expected none, got ch %0d width %0d frac %0d",
                             $time, out_data.channel, out_data.width, out_data.fraction);
                end
                else
                begin
                    due = pulses_due.pop_front();
                    if (out_data.channel !== due.channel || out_data.width !== due.width ||
                        out_data.fraction !== due.fraction)
                    begin
                        fail_count <= fail_count + 1;
                        $display("%0t: expected ch %0d w %0d f %0d, got ch %0d w %0d f %0d",
                                 $time, due.channel, due.width, due.fraction,
                                 out_data.channel, out_data.width, out_data.fraction);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                ch = -1;
                for (int k = CHANNELS - 1; k >= 0; k--)
                begin
                    if (pin_map[k] == in_data.pin)
                        ch = k;
                end
                if (ch >= 0)
                begin
                    if (in_data.level == LEVEL_RISE)
                    begin
                        rise_at[ch] = in_data.tick[TICK_BITS-1:0];
                    end
                    else if (in_data.level == LEVEL_FALL && rise_at[ch] != '0)
                    begin
                        due.channel  = 2'(ch);
                        due.width    = WIDTH_W'(in_data.tick[TICK_BITS-1:0] - rise_at[ch]);
                        due.fraction = pulse_fraction(due.width);
                        pulses_due.push_back(due);
                    end
                end
            end
            pending <= pulses_due.size();
        end
    end

endmodule

>>> verif/rc_pulse_width_capture_core_tb.sv
// ----------------------------------------------------------------------------
// rc_pulse_width_capture_core_tb
// stimulus and verdict for the rc pulse width capture core
// ----------------------------------------------------------------------------
// Starts with directed edges on the reset settings: missing rise, rise at
// tick zero, repeated falls, wrap-around, clamping at both ends, ignored
// levels and unmapped pins. Then runs through several register settings
// (shared pins, full range, empty and inverted range, a range of one tick)
// with random pulse trains, lone edges and noise. Both sides idle at random.
// The checker beside the core does all prediction and comparison.
module rc_pulse_width_capture_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcpwc_pkg::*;

    localparam int STALL_LIMIT      = 2000;
    localparam int SETTLE_CYCLES    = 40;
    localparam int PHASES           = 7;
    localparam int TRAINS_PER_PHASE = 24;

    localparam logic [1:0] LEVEL_TIMEOUT = 2'd2;
    localparam logic [1:0] LEVEL_UNUSED  = 2'd3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    rcpwc_in_t            in_data   = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;
    logic                 in_ready;
    logic                 out_valid;
    rcpwc_out_t           out_data;
    logic                 cfg_ready;
    int                   fail_count;
    int                   pending;

    bit                   src_fast     = 1'b0;
    bit                   sink_fast    = 1'b0;
    int                   sink_wait    = 0;
    int                   stall_cycles = 0;
    logic [PIN_W-1:0]     pins [CHANNELS];
    logic [WIDTH_W-1:0]   lo_w;
    logic [WIDTH_W-1:0]   hi_w;

    rc_pulse_width_capture_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rc_pulse_width_capture_core_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result sink with random stalls
    always @(posedge clk or negedge rst_n)
    begin : sink
        int draw;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_wait <= 0;
        end
        else if (out_valid && out_ready)
        begin
            draw = sink_fast ? 0 : $urandom_range(11, 0);
            if ($urandom_range(19, 0) == 0)
                sink_fast <= !sink_fast;
            sink_wait <= draw;
            out_ready <= (draw == 0);
        end
        else if (sink_wait > 0)
        begin
            sink_wait <= sink_wait - 1;
            out_ready <= (sink_wait == 1);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("rc_pulse_width_capture_core_tb NOT OK");
        $finish;
    end

    task automatic send_edge(input logic [PIN_W-1:0] p, input logic [1:0] lv,
                             input logic [31:0] t);
        int gap;
        gap = src_fast ? 0 : $urandom_range(11, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{pin: p, level: lv, tick: t};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings();
        for (int k = 0; k < CHANNELS + 2; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(k);
            if (k < CHANNELS)
                cfg_data <= 32'(pins[k]);
            else if (k == REG_MIN_WIDTH)
                cfg_data <= lo_w;
            else
                cfg_data <= hi_w;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] draw_width();
        case ($urandom_range(7, 0))
            0: return $urandom;
            1: return lo_w + $urandom_range(2, 0) - 1;
            2: return hi_w + $urandom_range(2, 0) - 1;
            default:
            begin
                if (hi_w > lo_w)
                    return lo_w + $urandom_range(hi_w - lo_w, 0);
                return lo_w + $urandom_range(4000, 0);
            end
        endcase
    endfunction

    // rise, optional pulse on a random channel (may be the same one), one or two falls
    task automatic pulse_train();
        int          k;
        int          j;
        int          falls;
        logic [31:0] t0;
        logic [31:0] t1;
        k  = $urandom_range(CHANNELS - 1, 0);
        j  = $urandom_range(CHANNELS - 1, 0);
        t0 = $urandom;
        t1 = $urandom;
        send_edge(pins[k], LEVEL_RISE, t0);
        if ($urandom_range(3, 0) == 0)
        begin
            send_edge(pins[j], LEVEL_RISE, t1);
            send_edge(pins[j], LEVEL_FALL, t1 + draw_width());
        end
        falls = ($urandom_range(4, 0) == 0) ? 2 : 1;
        repeat (falls) send_edge(pins[k], LEVEL_FALL, t0 + draw_width());
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: pins 0..3, range 1000..2000
        send_edge(5'd0, LEVEL_FALL, 32'd500);
        send_edge(5'd0, LEVEL_RISE, 32'd100);
        send_edge(5'd0, LEVEL_FALL, 32'd1600);
        send_edge(5'd0, LEVEL_FALL, 32'd2100);
        send_edge(5'd0, LEVEL_FALL, 32'd4000);
        send_edge(5'd1, LEVEL_RISE, 32'd0);
        send_edge(5'd1, LEVEL_FALL, 32'd1500);
        send_edge(5'd2, LEVEL_RISE, 32'hFFFF_FF00);
        send_edge(5'd2, LEVEL_FALL, 32'h0000_0100);
        send_edge(5'd3, LEVEL_RISE, 32'hFFFF_FFFF);
        send_edge(5'd3, LEVEL_FALL, 32'hFFFF_FFFF);
        send_edge(5'd3, LEVEL_TIMEOUT, 32'd1234);
        send_edge(5'd3, LEVEL_UNUSED, 32'h5555_AAAA);
        send_edge(5'd31, LEVEL_RISE, 32'd77);
        send_edge(5'd31, LEVEL_FALL, 32'd900);
        send_edge(5'd2, LEVEL_RISE, 32'h8000_0000);
        send_edge(5'd2, LEVEL_FALL, 32'h8000_03E8);
        send_edge(5'd2, LEVEL_FALL, 32'h8000_07CF);
        send_edge(5'd1, LEVEL_RISE, 32'hAAAA_AAAA);
        send_edge(5'd1, LEVEL_FALL, 32'h5555_5555);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            for (int k = 0; k < CHANNELS; k++)
                pins[k] = PIN_W'($urandom_range(31, 0));
            case (p)
                0:
                begin
                    pins = '{5'd0, 5'd1, 5'd2, 5'd3};
                    lo_w = 32'd1000;
                    hi_w = 32'd2000;
                end
                1:
                begin
                    pins = '{5'd7, 5'd7, 5'd31, 5'd7};
                    lo_w = 32'd0;
                    hi_w = 32'hFFFF_FFFF;
                end
                2:
                begin
                    lo_w = 32'd5000;
                    hi_w = 32'd5000;
                end
                3:
                begin
                    lo_w = 32'd3000;
                    hi_w = 32'd2000;
                end
                4:
                begin
                    pins = '{5'd4, 5'd9, 5'd14, 5'd30};
                    lo_w = 32'd1000;
                    hi_w = 32'd1001;
                end
                5:
                begin
                    lo_w = 32'd0;
                    hi_w = 32'd65535;
                end
                default:
                begin
                    lo_w = $urandom_range(50000, 0);
                    hi_w = lo_w + $urandom_range(100000, 1);
                end
            endcase
            load_settings();

            for (int n = 0; n < TRAINS_PER_PHASE; )
            begin
                case ($urandom_range(9, 0))
                    0: send_edge(PIN_W'($urandom_range(31, 0)), 2'($urandom_range(3, 0)),
                                 $urandom);
                    1: send_edge(pins[$urandom_range(CHANNELS - 1, 0)],
                                 $urandom_range(1, 0) ? LEVEL_RISE : LEVEL_FALL, $urandom);
                    default:
                    begin
                        pulse_train();
                        n++;
                    end
                endcase
                if ($urandom_range(19, 0) == 0)
                    src_fast = !src_fast;
                if ($urandom_range(39, 0) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("rc_pulse_width_capture_core_tb OK");
        else
            $display("rc_pulse_width_capture_core_tb NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
src/rcpwc_pkg.sv
src/rcpwc_divider.sv
src/rcpwc_datapath.sv
src/rcpwc_ctrl.sv
src/rc_pulse_width_capture_core.sv
verif/rc_pulse_width_capture_core_checker.sv
verif/rc_pulse_width_capture_core_tb.sv
